FILE: design/bfa_pkg.sv
// Shared types, constants and bit-search functions for the bitmap allocator.
package bfa_pkg;

    localparam int MAX_WORDS = 32;
    localparam int WORD_BITS = 32;
    localparam int ADDR_W    = $clog2(MAX_WORDS);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int IDX_W     = 10;
    localparam int CFG_W     = 6;
    localparam int IWORD_W   = IDX_W - BIT_W;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [MAX_WORDS-1:0] wmask_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [BIT_W-1:0]     bit_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CFG_W-1:0]     cfg_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_DOUBLE = 2'd2,
        ST_RANGE  = 2'd3
    } status_t;

    // Result of the read-modify step on one bitmap word.
    typedef struct packed {
        logic    we;
        word_t   new_word;
        bit_t    bit_idx;
        status_t status;
        logic    nonempty;
    } mod_res_t;

    // Position of the lowest set bit; isolate it, then encode the one-hot.
    function automatic bit_t lowest_bit(input word_t v);
        word_t onehot;
        bit_t  res;
        onehot = v & (~v + word_t'(1));
        res    = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            for (int k = 0; k < BIT_W; k++)
            begin
                if (((j >> k) & 1) != 0)
                    res[k] = res[k] | onehot[j];
            end
        end
        return res;
    endfunction

    function automatic addr_t lowest_word(input wmask_t v);
        wmask_t onehot;
        addr_t  res;
        onehot = v & (~v + wmask_t'(1));
        res    = '0;
        for (int j = 0; j < MAX_WORDS; j++)
        begin
            for (int k = 0; k < ADDR_W; k++)
            begin
                if (((j >> k) & 1) != 0)
                    res[k] = res[k] | onehot[j];
            end
        end
        return res;
    endfunction

endpackage

FILE: design/bitmap_lowest_free_allocator.sv
// Top level of the first-fit bitmap allocator: control, summary flags, output register.
//
// Usage:
//   s_* channel takes one request item: s_tuser[0] is mode (0 allocate,
//   1 free), s_tdata[9:0] the entry to free. m_* channel returns one result
//   item per request: m_tdata[9:0] the granted entry, m_tuser[1:0] the status
//   (0 ok, 1 full, 2 already free, 3 out of range).
//   cfg_* writes words_in_use (values above 32 act as 32); write only when idle.
// Sequence:
//   When the bitmap word is touched, an item passes accept, RAM read,
//   modify and write back, and load of the output register. Full and
//   out-of-range requests are decided at accept and go straight to the load.
//   The sequence is set by the registered read data of the bitmap RAM and
//   the read-modify-write on it; the lowest free word is found in one step
//   from a per-word "has free entry" summary held in flip-flops.
// Reset:
//   All entries read as free at once: a per-word written flag makes an
//   unwritten word read as all ones, so no clearing pass is needed.
//   words_in_use resets to 32.
// Stall:
//   A finished result waits in the output register until m_tready; the
//   next request is not accepted until that result has been loaded.
module bitmap_lowest_free_allocator (
    input  logic        clk,
    input  logic        rst_n,
    // request
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] index, rest zero
    input  logic [0:0]  s_tuser,   // [0] mode
    // result
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [9:0] granted_index, rest zero
    output logic [1:0]  m_tuser,   // [1:0] status
    // configuration: words_in_use
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data   // [5:0] words_in_use
);
    import bfa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MODIFY,
        S_OUT
    } state_t;

    state_t   state_reg, state_next;
    logic     op_reg, op_next;
    addr_t    addr_reg, addr_next;
    bit_t     bit_reg, bit_next;
    status_t  status_reg, status_next;
    idx_t     granted_reg, granted_next;
    cfg_t     words_reg, words_next;
    wmask_t   valid_reg, valid_next;     // word has been written since reset
    wmask_t   summary_reg, summary_next; // word has at least one free entry
    logic     out_valid_reg, out_valid_next;
    idx_t     out_index_reg, out_index_next;
    status_t  out_status_reg, out_status_next;

    cfg_t       nwords;
    wmask_t     use_mask;
    wmask_t     avail;
    logic [IWORD_W-1:0] idx_word;
    word_t      rd_data;
    word_t      cur_word;
    mod_res_t   mres;
    logic       ram_re;
    logic       ram_we;

    assign nwords = (words_reg > cfg_t'(MAX_WORDS)) ? cfg_t'(MAX_WORDS) : words_reg;

    always_comb
    begin
        for (int w = 0; w < MAX_WORDS; w++)
            use_mask[w] = cfg_t'(w) < nwords;
    end

    assign avail    = summary_reg & use_mask;
    assign idx_word = s_tdata[IDX_W-1:BIT_W];

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(16-IDX_W){1'b0}}, out_index_reg};
    assign m_tuser   = out_status_reg;

    assign ram_re   = (state_reg == S_READ);
    assign ram_we   = (state_reg == S_MODIFY) && mres.we;
    assign cur_word = valid_reg[addr_reg] ? rd_data : '1;

    bfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAX_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (mres.new_word),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (rd_data)
    );

    bfa_modify u_modify (
        .op       (op_reg),
        .bit_sel  (bit_reg),
        .cur_word (cur_word),
        .res      (mres)
    );

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        bit_next        = bit_reg;
        status_next     = status_reg;
        granted_next    = granted_reg;
        words_next      = words_reg;
        valid_next      = valid_reg;
        summary_next    = summary_reg;
        out_valid_next  = out_valid_reg;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;

        if (cfg_valid && cfg_ready)
            words_next = cfg_data;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next      = s_tuser[0];
                    granted_next = '0;
                    if (s_tuser[0] == MODE_ALLOC)
                    begin
                        if (avail == '0)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            addr_next  = lowest_word(avail);
                            state_next = S_READ;
                        end
                    end
                    else if (cfg_t'(idx_word) >= nwords)
                    begin
                        status_next = ST_RANGE;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        addr_next  = idx_word[ADDR_W-1:0];
                        bit_next   = s_tdata[BIT_W-1:0];
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_MODIFY;
            end
            S_MODIFY:
            begin
                status_next = mres.status;
                if (mres.we)
                begin
                    valid_next[addr_reg]   = 1'b1;
                    summary_next[addr_reg] = mres.nonempty;
                end
                if (op_reg == MODE_ALLOC)
                    granted_next = idx_t'({addr_reg, mres.bit_idx});
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = granted_reg;
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            words_reg     <= cfg_t'(32);
            valid_reg     <= '0;
            summary_reg   <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            words_reg     <= words_next;
            valid_reg     <= valid_next;
            summary_reg   <= summary_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        addr_reg       <= addr_next;
        bit_reg        <= bit_next;
        status_reg     <= status_next;
        granted_reg    <= granted_next;
        out_index_reg  <= out_index_next;
        out_status_reg <= out_status_next;
    end

endmodule

FILE: design/bfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

FILE: design/bfa_modify.sv
// Modify step: clears the lowest free bit or sets a freed bit in one word.
module bfa_modify (
    input  logic              op,
    input  bfa_pkg::bit_t     bit_sel,
    input  bfa_pkg::word_t    cur_word,
    output bfa_pkg::mod_res_t res
);
    import bfa_pkg::*;

    bit_t  alloc_bit;
    word_t alloc_mask;
    word_t free_mask;

    assign alloc_bit  = lowest_bit(cur_word);
    assign alloc_mask = word_t'(1) << alloc_bit;
    assign free_mask  = word_t'(1) << bit_sel;

    always_comb
    begin
        res = '0;
        if (op == MODE_ALLOC)
        begin
            // word was picked from the summary, so it has a free bit
            res.we       = 1'b1;
            res.new_word = cur_word & ~alloc_mask;
            res.bit_idx  = alloc_bit;
            res.status   = ST_OK;
        end
        else if (cur_word[bit_sel])
        begin
            res.we       = 1'b0;
            res.new_word = cur_word;
            res.bit_idx  = bit_sel;
            res.status   = ST_DOUBLE;
        end
        else
        begin
            res.we       = 1'b1;
            res.new_word = cur_word | free_mask;
            res.bit_idx  = bit_sel;
            res.status   = ST_OK;
        end
        res.nonempty = |res.new_word;
    end

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the first-fit bitmap allocator.
module testbench;
    import bfa_pkg::*;

    localparam int DRAIN_CYCLES   = 8;     // settling time after the last result is back
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on any channel
    localparam int GAP_MAX        = 14;

    // expected result of one request
    typedef struct packed {
        idx_t    granted;
        status_t status;
    } grant_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [9:0] index, rest zero
    logic [0:0]  s_tuser;   // [0] mode
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [9:0] granted_index, rest zero
    logic [1:0]  m_tuser;   // [1:0] status
    logic        cfg_valid;
    logic        cfg_ready;
    logic [5:0]  cfg_data;  // [5:0] words_in_use

    // shadow of the allocator: free bitmap and word count
    bit [WORD_BITS-1:0] shadow_map [MAX_WORDS];
    cfg_t               shadow_words;
    grant_t             grants_due [$];

    int          tx_gap_max;
    int          rx_gap_max;
    int unsigned requests_sent;
    int unsigned cfg_writes;
    int unsigned errors;
    int unsigned status_seen [4];
    int unsigned idle_cycles;

    bitmap_lowest_free_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // entries managed under the current word count (saturates at MAX_WORDS)
    function automatic int entries_in_use();
        return ((shadow_words > MAX_WORDS) ? MAX_WORDS : int'(shadow_words)) * WORD_BITS;
    endfunction

    // Apply one accepted request to the shadow map and queue the expected result.
    function automatic void apply_request(input logic mode, input idx_t index);
        grant_t res;
        int     nwords;
        int     w;
        int     b;
        bit     hit;
        nwords      = entries_in_use() / WORD_BITS;
        res.granted = '0;
        hit         = 1'b0;
        if (mode == MODE_ALLOC)
        begin
            res.status = ST_FULL;
            for (w = 0; w < nwords && !hit; w++)
            begin
                for (b = 0; b < WORD_BITS && !hit; b++)
                begin
                    if (shadow_map[w][b])
                    begin
                        shadow_map[w][b] = 1'b0;
                        res.granted      = idx_t'(w * WORD_BITS + b);
                        res.status       = ST_OK;
                        hit              = 1'b1;
                    end
                end
            end
        end
        else if (int'(index) >= nwords * WORD_BITS)
            res.status = ST_RANGE;
        else if (shadow_map[index / WORD_BITS][index % WORD_BITS])
            res.status = ST_DOUBLE;
        else
        begin
            shadow_map[index / WORD_BITS][index % WORD_BITS] = 1'b1;
            res.status = ST_OK;
        end
        grants_due.push_back(res);
    endfunction

    // Mostly an entry that is currently allocated, some in-range guesses, some anywhere.
    function automatic idx_t pick_free_target();
        int   span;
        int   roll;
        idx_t cand;
        span = entries_in_use();
        roll = $urandom_range(0, 99);
        if (span == 0 || roll >= 85)
            return idx_t'($urandom);
        cand = idx_t'($urandom_range(0, span - 1));
        if (roll < 70)
        begin
            repeat (16)
            begin
                if (shadow_map[cand / WORD_BITS][cand % WORD_BITS])
                    cand = idx_t'($urandom_range(0, span - 1));
            end
        end
        return cand;
    endfunction

    // Redraw idling: each side gets full-range gaps or back-to-back stretches, half the time each.
    task automatic draw_idle_mix();
        int roll;
        roll       = $urandom_range(0, 3);
        tx_gap_max = (roll == 0 || roll == 1) ? 0 : GAP_MAX;
        rx_gap_max = (roll == 0 || roll == 2) ? 0 : GAP_MAX;
    endtask

    // Send one request item; the shadow is updated at the accepting edge.
    task automatic send_request(input logic mode, input idx_t index);
        int gap;
        gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {6'b0, index};
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        apply_request(mode, index);
        requests_sent++;
    endtask

    // Block until every expected result is back, then let the pipeline settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (grants_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_words(input cfg_t value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid    <= 1'b0;
        shadow_words  = value;
        cfg_writes++;
    endtask

    // Corner cases: first grants, reuse of a freed hole, double free, zero words,
    // saturating word count, out-of-range frees, field extremes.
    task automatic test_directed();
        tx_gap_max = GAP_MAX;
        rx_gap_max = GAP_MAX;
        send_request(MODE_ALLOC, '0);
        send_request(MODE_ALLOC, '1);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, idx_t'(1));
        send_request(MODE_FREE, idx_t'(1));      // already free
        send_request(MODE_ALLOC, '0);            // refills the hole at 1
        send_request(MODE_FREE, '1);             // top entry, never allocated
        send_request(MODE_FREE, '0);
        send_request(MODE_ALLOC, '0);
        write_words(cfg_t'(0));                  // nothing managed
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, '0);
        write_words('1);                         // 63 acts as 32
        send_request(MODE_FREE, '0);
        send_request(MODE_ALLOC, '1);
        send_request(MODE_FREE, '1);
        write_words(cfg_t'(1));
        send_request(MODE_FREE, idx_t'(WORD_BITS));      // first entry past range
        send_request(MODE_FREE, idx_t'(WORD_BITS - 1));
    endtask

    // One word only: run it to full, then punch holes and refill.
    task automatic test_small_store();
        write_words(cfg_t'(1));
        draw_idle_mix();
        repeat (WORD_BITS + 2)
            send_request(MODE_ALLOC, idx_t'($urandom));
        repeat (24)
        begin
            if ($urandom_range(0, 1) == 0)
                send_request(MODE_ALLOC, idx_t'($urandom));
            else
                send_request(MODE_FREE, pick_free_target());
        end
    endtask

    task automatic run_phase(input cfg_t words, input int count, input int alloc_pct);
        int n;
        write_words(words);
        for (n = 0; n < count; n++)
        begin
            if (n % 50 == 0)
                draw_idle_mix();
            if ($urandom_range(1, 100) <= alloc_pct)
                send_request(MODE_ALLOC, idx_t'($urandom));
            else
                send_request(MODE_FREE, pick_free_target());
        end
    endtask

    // Store persists across word-count changes, so later phases see a crowded map.
    task automatic test_random_phases();
        run_phase(cfg_t'(32), 600, 95);   // fill deep, grants past entry 512
        run_phase(cfg_t'(5), 80, 50);     // range already full: full/ok/range mix
        run_phase(cfg_t'(33), 100, 50);
        run_phase('1, 80, 40);
        run_phase(cfg_t'(0), 30, 50);
        run_phase(cfg_t'($urandom_range(1, 20)), 150, 55);
        run_phase(cfg_t'(32), 110, 20);   // drain
    endtask

    // Result receiver: random stall before each result.
    initial
    begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = (rx_gap_max > 0) ? $urandom_range(0, rx_gap_max) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        grant_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            status_seen[m_tuser]++;
            if (grants_due.size() == 0)
            begin
                $display("%0t: result with none pending: granted %0d status %0d",
                         $time, m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                want = grants_due.pop_front();
                if (m_tdata !== {6'b0, want.granted})
                begin
                    $display("%0t: granted_index expected %0d actual %0d",
                             $time, want.granted, m_tdata);
                    errors++;
                end
                if (m_tuser !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_tuser);
                    errors++;
                end
            end
        end
    end

    // Watchdog: any handshake restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("bitmap_lowest_free_allocator regression: fail");
            $finish;
        end
    end

    // errors, status_seen and idle_cycles are two-state and start at zero
    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        tx_gap_max    = 0;
        rx_gap_max    = 0;
        requests_sent = 0;
        cfg_writes    = 0;
        shadow_map    = '{default: '1};
        shadow_words  = cfg_t'(32);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_small_store();
        test_random_phases();
        wait_idle();

        $display("covered %0d requests over %0d word-count writes (0, 1, 32, 33, 63 and others)",
                 requests_sent, cfg_writes);
        $display("results seen: ok %0d, full %0d, already free %0d, out of range %0d",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_DOUBLE],
                 status_seen[ST_RANGE]);
        if (errors == 0)
            $display("bitmap_lowest_free_allocator regression: pass");
        else
            $display("bitmap_lowest_free_allocator regression: fail");
        $finish;
    end

endmodule
